// ===== design/kmg_pkg.sv =====
// Shared constants and types for the keyboard matrix ghost model.
package kmg_pkg;

    // Matrix geometry
    localparam int MAX_LINES = 16;
    localparam int MAX_COLS  = 16;
    localparam int KEY_W     = 16;
    localparam int CFG_W     = 5;

    // Lines per matrix never exceed the result cap of 16
    localparam int EFF_MAX   = (MAX_LINES < 16) ? MAX_LINES : 16;
    localparam int CNT_W     = $clog2(EFF_MAX + 1);
    localparam int IDX_W     = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;

    // Register indexes
    localparam logic CFG_LINES = 1'b0;
    localparam logic CFG_COLS  = 1'b1;

    // Commands broadcast to every cell
    typedef struct packed {
        logic write;   // store row_keys into the selected cell
        logic start;   // mask stored row, seed accumulator and ring
        logic rotate;  // one step of the ring compare
        logic shift;   // move results one cell toward the output
    } kmg_cmd_t;

endpackage

// ===== design/kmg_cell.sv =====
// One matrix line: stores the true row, accumulates ghosts from the ring.
module kmg_cell
    import kmg_pkg::*;
(
    input  logic             aclk,
    input  kmg_cmd_t         cmd,
    input  logic             wr_sel,
    input  logic [KEY_W-1:0] row_in,
    input  logic [KEY_W-1:0] col_mask,
    input  logic [KEY_W-1:0] ring_in,
    input  logic [KEY_W-1:0] own_in,
    input  logic [KEY_W-1:0] obs_in,
    output logic [KEY_W-1:0] ring_out,
    output logic [KEY_W-1:0] own_out,
    output logic [KEY_W-1:0] obs_out
);

    logic [KEY_W-1:0] row_reg;
    logic [KEY_W-1:0] own_reg;
    logic [KEY_W-1:0] obs_reg;
    logic [KEY_W-1:0] ring_reg;
    logic             hit;

    // Passing row shares a pressed column with this line
    assign hit = |(own_reg & ring_reg);

    always_ff @(posedge aclk) begin
        if (cmd.write && wr_sel) begin
            row_reg <= row_in;
        end
        if (cmd.start) begin
            own_reg  <= row_reg & col_mask;
            obs_reg  <= row_reg & col_mask;
            ring_reg <= row_reg & col_mask;
        end else if (cmd.rotate) begin
            if (hit) begin
                obs_reg <= obs_reg | ring_reg;
            end
            ring_reg <= ring_in;
        end else if (cmd.shift) begin
            own_reg <= own_in;
            obs_reg <= obs_in;
        end
    end

    assign ring_out = ring_reg;
    assign own_out  = own_reg;
    assign obs_out  = obs_reg;

endmodule

// ===== design/keyboard_matrix_ghost_model.sv =====
// Top level: load control, ring of line cells and result output register.
//
// Rows arrive one per transfer and are stored in a chain of line cells; the
// transfer that completes a matrix of n lines (n = lines_in_use clamped to
// 1..16) starts the compute. A start step masks the stored rows, then the
// rotate state moves every masked row once around a ring of n cells, each
// cell OR-ing in a passing row that shares a pressed column with its own.
// The n results are then shifted out of cell 0, one per cycle while the
// output side accepts. Beyond the n load transfers, a full matrix costs the
// start step, the ring rotation and the single shift-out path; input is not
// accepted from the completing transfer until the last result sits in the
// output register. Configuration writes are always accepted.
module keyboard_matrix_ghost_model
    import kmg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Row input
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,    // [15:0] row_keys
    // Result output
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,    // [15:0] observed_keys, [31:16] ghost_keys
    output logic             m_tlast,    // is_last
    // Configuration writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_START,
        ST_ROTATE,
        ST_DRAIN
    } state_t;

    state_t           state_reg,   state_next;
    logic [CFG_W-1:0] lines_reg,   lines_next;
    logic [CFG_W-1:0] cols_reg,    cols_next;
    logic [CNT_W-1:0] load_reg,    load_next;
    logic [CNT_W-1:0] n_reg,       n_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic [KEY_W-1:0] obs_reg,     obs_next;
    logic [KEY_W-1:0] ghost_reg,   ghost_next;
    logic             last_reg,    last_next;

    logic [CNT_W-1:0] n_eff;
    logic [CFG_W-1:0] c_eff;
    logic [KEY_W-1:0] col_mask;
    logic [CNT_W-1:0] wr_idx;
    logic             in_xfer;
    logic             out_free;
    kmg_cmd_t         cmd;

    logic [KEY_W-1:0] ring_q [EFF_MAX];
    logic [KEY_W-1:0] own_q  [EFF_MAX];
    logic [KEY_W-1:0] obs_q  [EFF_MAX];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_LOAD);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // Effective line count, clamped to 1..EFF_MAX
    always_comb begin
        if (lines_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(lines_reg) > 32'(EFF_MAX)) begin
            n_eff = CNT_W'(EFF_MAX);
        end else begin
            n_eff = CNT_W'(lines_reg);
        end
    end

    // Column mask from the clamped column count
    always_comb begin
        if (cols_reg == '0) begin
            c_eff = CFG_W'(1);
        end else if (32'(cols_reg) > 32'(MAX_COLS)) begin
            c_eff = CFG_W'(MAX_COLS);
        end else begin
            c_eff = cols_reg;
        end
        if (32'(c_eff) >= 32'(KEY_W)) begin
            col_mask = '1;
        end else begin
            col_mask = KEY_W'((33'd1 << c_eff) - 33'd1);
        end
    end

    // Load slot: a load longer than the current line count restarts at 0
    assign wr_idx = (load_reg < n_eff) ? load_reg : '0;

    // Cell commands
    always_comb begin
        cmd.write  = in_xfer;
        cmd.start  = (state_reg == ST_START);
        cmd.rotate = (state_reg == ST_ROTATE);
        cmd.shift  = (state_reg == ST_DRAIN) && out_free;
    end

    // Chain of line cells; the ring closes at cell n-1
    for (genvar g = 0; g < EFF_MAX; g++) begin : g_cell
        logic [KEY_W-1:0] ring_src;
        logic [KEY_W-1:0] own_src;
        logic [KEY_W-1:0] obs_src;

        if (g == EFF_MAX - 1) begin : g_end
            assign ring_src = ring_q[0];
            assign own_src  = '0;
            assign obs_src  = '0;
        end else begin : g_mid
            assign ring_src = (n_reg == CNT_W'(g + 1)) ? ring_q[0] : ring_q[g + 1];
            assign own_src  = own_q[g + 1];
            assign obs_src  = obs_q[g + 1];
        end

        kmg_cell u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .wr_sel   (wr_idx[IDX_W-1:0] == IDX_W'(g)),
            .row_in   (s_tdata),
            .col_mask (col_mask),
            .ring_in  (ring_src),
            .own_in   (own_src),
            .obs_in   (obs_src),
            .ring_out (ring_q[g]),
            .own_out  (own_q[g]),
            .obs_out  (obs_q[g])
        );
    end

    // Sequencer and output register
    always_comb begin
        state_next   = state_reg;
        lines_next   = lines_reg;
        cols_next    = cols_reg;
        load_next    = load_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        obs_next     = obs_reg;
        ghost_next   = ghost_reg;
        last_next    = last_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LINES: lines_next = cfg_data;
                CFG_COLS:  cols_next  = cfg_data;
                default:   ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (wr_idx + CNT_W'(1) == n_eff) begin
                        load_next  = '0;
                        n_next     = n_eff;
                        state_next = ST_START;
                    end else begin
                        load_next = wr_idx + CNT_W'(1);
                    end
                end
            end
            ST_START: begin
                cnt_next   = '0;
                state_next = ST_ROTATE;
            end
            ST_ROTATE: begin
                if (cnt_reg == n_reg - CNT_W'(1)) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    obs_next     = obs_q[0];
                    ghost_next   = obs_q[0] & ~own_q[0];
                    last_next    = (cnt_reg == n_reg - CNT_W'(1));
                    cnt_next     = cnt_reg + CNT_W'(1);
                    if (cnt_reg == n_reg - CNT_W'(1)) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            lines_reg   <= CFG_W'(16);
            cols_reg    <= CFG_W'(16);
            load_reg    <= '0;
            n_reg       <= CNT_W'(1);
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lines_reg   <= lines_next;
            cols_reg    <= cols_next;
            load_reg    <= load_next;
            n_reg       <= n_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        obs_reg   <= obs_next;
        ghost_reg <= ghost_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {ghost_reg, obs_reg};
    assign m_tlast  = last_reg;

endmodule
